// ===== hw/rtl/mexp_pkg.sv =====
// shared types and constants for the modular exponentiation unit
package mexp_pkg;

  // width of the serial multiplier's scanned operand (the base field width)
  localparam int OPA_W = 32;
  // step counter width, holds up to OPA_W
  localparam int STEP_W = 6;
  // modulus after reset, before masking to the configured width
  localparam logic [31:0] MOD_RESET = 32'd998244353;

  // register indexes of the configuration port
  localparam logic REG_MODULUS = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_BIT,
    S_MUL,
    S_SQR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } mm_cmd_t;

endpackage

// ===== hw/rtl/mexp_modmul.sv =====
// bit-serial interleaved modular multiplier, one operand bit per cycle
module mexp_modmul #(
  parameter int MOD_BITS = 31
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mexp_pkg::mm_cmd_t             cmd,
  input  logic [mexp_pkg::OPA_W-1:0]    op_a,
  input  logic [MOD_BITS-1:0]           op_b,
  input  logic [MOD_BITS-1:0]           modulus,
  output logic                          done,
  output logic [MOD_BITS-1:0]           product
);

  logic [MOD_BITS-1:0]          acc;
  logic [MOD_BITS-1:0]          acc_next;
  logic [mexp_pkg::OPA_W-1:0]   a_sh;
  logic [MOD_BITS-1:0]          b_r;
  logic [mexp_pkg::STEP_W-1:0]  cnt;
  logic                         busy;

  logic [MOD_BITS:0] m_ext;
  logic [MOD_BITS:0] dbl;
  logic [MOD_BITS:0] dbl_red;
  logic [MOD_BITS:0] addend;
  logic [MOD_BITS:0] sum;
  logic [MOD_BITS:0] sum_red;

  // acc < m and b < m keep every intermediate below 2m
  always_comb begin
    m_ext   = {1'b0, modulus};
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    addend  = a_sh[mexp_pkg::OPA_W-1] ? {1'b0, b_r} : '0;
    sum     = dbl_red + addend;
    sum_red = (sum >= m_ext) ? sum - m_ext : sum;
    acc_next = sum_red[MOD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == mexp_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc  <= '0;
      a_sh <= op_a;
      b_r  <= op_b;
    end else if (busy) begin
      acc  <= acc_next;
      a_sh <= {a_sh[mexp_pkg::OPA_W-2:0], 1'b0};
    end
  end

  assign product = acc;

endmodule

// ===== hw/rtl/modular_exponentiation_unit.sv =====
// work on an item: a base reduction, then for each exponent bit up to the highest set one
// a square, preceded by a multiply when the bit is set,
// all done in turn by the one serial multiplier
// one item at a time; the next item is taken while a finished result waits at the output
// synchronous reset clears the control state and sets the modulus to 998244353
// top level: modular exponentiation by right-to-left square-and-multiply
module modular_exponentiation_unit #(
  parameter int EXP_BITS = 32,
  parameter int MOD_BITS = 31
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] base_value,
  input  logic [31:0] exponent,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] power_result,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [MOD_BITS-1:0] ONE = MOD_BITS'(1);

  mexp_pkg::state_t state;
  mexp_pkg::state_t state_next;

  logic [MOD_BITS-1:0]        modulus;
  logic [EXP_BITS-1:0]        exp_r;
  logic [MOD_BITS-1:0]        acc;
  logic [MOD_BITS-1:0]        bsq;
  logic [63:0]                exp_wide;
  logic [31:0]                acc_ext;
  logic                       m_small;
  logic                       out_load;

  mexp_pkg::mm_cmd_t              mm_cmd;
  logic [mexp_pkg::OPA_W-1:0]     mm_a;
  logic [MOD_BITS-1:0]            mm_b;
  logic                           mm_done;
  logic [MOD_BITS-1:0]            mm_product;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == mexp_pkg::REG_MODULUS) ? 32'(modulus) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mexp_pkg::MOD_RESET[MOD_BITS-1:0];
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == mexp_pkg::REG_MODULUS) begin
      modulus <= pwdata[MOD_BITS-1:0];
    end
  end

  // a modulus of zero or one forces a zero result
  assign m_small  = (modulus[MOD_BITS-1:1] == '0);
  assign exp_wide = 64'(exponent);
  assign acc_ext  = 32'(acc);

  mexp_modmul #(
    .MOD_BITS(MOD_BITS)
  ) u_modmul (
    .clk     (clk),
    .rst     (rst),
    .cmd     (mm_cmd),
    .op_a    (mm_a),
    .op_b    (mm_b),
    .modulus (modulus),
    .done    (mm_done),
    .product (mm_product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mexp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    mm_cmd.start = 1'b0;
    mm_cmd.steps = mexp_pkg::STEP_W'(MOD_BITS);
    mm_a         = {acc, {(mexp_pkg::OPA_W-MOD_BITS){1'b0}}};
    mm_b         = bsq;
    out_load     = 1'b0;
    in_stall     = (state != mexp_pkg::S_IDLE);
    unique case (state)
      mexp_pkg::S_IDLE: begin
        if (in_valid) begin
          if (m_small) begin
            state_next = mexp_pkg::S_FINISH;
          end else begin
            // base mod m as base * 1 over all base bits
            mm_cmd.start = 1'b1;
            mm_cmd.steps = mexp_pkg::STEP_W'(mexp_pkg::OPA_W);
            mm_a         = base_value;
            mm_b         = ONE;
            state_next   = mexp_pkg::S_REDUCE;
          end
        end
      end
      mexp_pkg::S_REDUCE: begin
        if (mm_done) begin
          state_next = mexp_pkg::S_BIT;
        end
      end
      mexp_pkg::S_BIT: begin
        if (exp_r == '0) begin
          state_next = mexp_pkg::S_FINISH;
        end else if (exp_r[0]) begin
          mm_cmd.start = 1'b1;
          state_next   = mexp_pkg::S_MUL;
        end else begin
          mm_cmd.start = 1'b1;
          mm_a         = {bsq, {(mexp_pkg::OPA_W-MOD_BITS){1'b0}}};
          state_next   = mexp_pkg::S_SQR;
        end
      end
      mexp_pkg::S_MUL: begin
        if (mm_done) begin
          mm_cmd.start = 1'b1;
          mm_a         = {bsq, {(mexp_pkg::OPA_W-MOD_BITS){1'b0}}};
          state_next   = mexp_pkg::S_SQR;
        end
      end
      mexp_pkg::S_SQR: begin
        if (mm_done) begin
          state_next = mexp_pkg::S_BIT;
        end
      end
      mexp_pkg::S_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = mexp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mexp_pkg::S_IDLE;
      end
    endcase
  end

  // running accumulator, squared base and remaining exponent bits
  always_ff @(posedge clk) begin
    if (state == mexp_pkg::S_IDLE && in_valid) begin
      exp_r <= exp_wide[EXP_BITS-1:0];
      acc   <= m_small ? '0 : ONE;
    end
    if (state == mexp_pkg::S_REDUCE && mm_done) begin
      bsq <= mm_product;
    end
    if (state == mexp_pkg::S_MUL && mm_done) begin
      acc <= mm_product;
    end
    if (state == mexp_pkg::S_SQR && mm_done) begin
      bsq   <= mm_product;
      exp_r <= exp_r >> 1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      power_result <= acc_ext[30:0];
    end
  end

endmodule

// ===== hw/rtl/mexp_checker.sv =====
// port-level checks for the modular exponentiation unit, bound to the top level
module mexp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [30:0] power_result
);

  // a waiting result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a waiting result holds its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(power_result))
    else $error("result changed while stalled");

  // an accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block idle right after accepting an item");

  // a new result only appears at the end of work on an item
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in progress");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .power_result (power_result)
);
